// File: rtl/yttm_pkg.sv
package yttm_pkg;

  localparam int unsigned MAX_MB_COLS_DEF = 256;
  localparam int unsigned MAX_MB_ROWS_DEF = 256;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned MB_DIM_W = 9;
  localparam int unsigned FIRST_ROW_W = 8;

  localparam logic [MB_DIM_W-1:0]    WIDTH_MBS_RST    = 9'd40;
  localparam logic [MB_DIM_W-1:0]    HEIGHT_MBS_RST   = 9'd30;
  localparam logic [FIRST_ROW_W-1:0] FIRST_MB_ROW_RST = 8'd0;
  localparam logic [MB_DIM_W-1:0]    MB_ROW_COUNT_RST = 9'd30;

  typedef enum logic [1:0] {
    REG_WIDTH_MBS    = 2'd0,
    REG_HEIGHT_MBS   = 2'd1,
    REG_FIRST_MB_ROW = 2'd2,
    REG_MB_ROW_COUNT = 2'd3
  } reg_idx_e;

  // clamped settings (first_mb_row passes unclamped) and counter clear strobe
  typedef struct packed {
    logic [MB_DIM_W-1:0]    width_mbs;
    logic [MB_DIM_W-1:0]    height_mbs;
    logic [FIRST_ROW_W-1:0] first_mb_row;
    logic [MB_DIM_W-1:0]    row_count;
    logic                   clr;
  } cfg_t;

endpackage

// File: rtl/yttm_if.sv
interface yttm_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_pair;

  modport source (output valid, output pixel_pair, input ready);
  modport sink (input valid, input pixel_pair, output ready);
endinterface

interface yttm_mb_if;
  logic        valid;
  logic        ready;
  logic [23:0] luma_offset;
  logic [15:0] luma_bytes;
  logic        chroma_valid;
  logic [24:0] u_offset;
  logic [7:0]  u_byte;
  logic [24:0] v_offset;
  logic [7:0]  v_byte;
  logic        band_done;

  modport source (
    output valid, output luma_offset, output luma_bytes, output chroma_valid,
    output u_offset, output u_byte, output v_offset, output v_byte,
    output band_done, input ready
  );
  modport sink (
    input valid, input luma_offset, input luma_bytes, input chroma_valid,
    input u_offset, input u_byte, input v_offset, input v_byte,
    input band_done, output ready
  );
endinterface

// File: rtl/yttm_cfg_regs.sv
module yttm_cfg_regs #(
  parameter int unsigned MAX_MB_COLS = yttm_pkg::MAX_MB_COLS_DEF,
  parameter int unsigned MAX_MB_ROWS = yttm_pkg::MAX_MB_ROWS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [yttm_pkg::PADDR_W-1:0]  paddr,
  input  logic [yttm_pkg::PDATA_W-1:0]  pwdata,
  output logic [yttm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output yttm_pkg::cfg_t                cfg_o
);

  localparam logic [yttm_pkg::MB_DIM_W-1:0] MaxCols = yttm_pkg::MB_DIM_W'(MAX_MB_COLS);
  localparam logic [yttm_pkg::MB_DIM_W-1:0] MaxRows = yttm_pkg::MB_DIM_W'(MAX_MB_ROWS);

  logic [yttm_pkg::MB_DIM_W-1:0]    width_mbs_q;
  logic [yttm_pkg::MB_DIM_W-1:0]    height_mbs_q;
  logic [yttm_pkg::FIRST_ROW_W-1:0] first_mb_row_q;
  logic [yttm_pkg::MB_DIM_W-1:0]    mb_row_count_q;
  logic                             wr_en;
  yttm_pkg::reg_idx_e               idx;

  function automatic logic [yttm_pkg::MB_DIM_W-1:0] clamp(
    input logic [yttm_pkg::MB_DIM_W-1:0] v,
    input logic [yttm_pkg::MB_DIM_W-1:0] hi
  );
    logic [yttm_pkg::MB_DIM_W-1:0] r;
    if (v == '0) begin
      r = yttm_pkg::MB_DIM_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = yttm_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_mbs_q    <= yttm_pkg::WIDTH_MBS_RST;
      height_mbs_q   <= yttm_pkg::HEIGHT_MBS_RST;
      first_mb_row_q <= yttm_pkg::FIRST_MB_ROW_RST;
      mb_row_count_q <= yttm_pkg::MB_ROW_COUNT_RST;
    end else if (wr_en) begin
      case (idx)
        yttm_pkg::REG_WIDTH_MBS:    width_mbs_q    <= pwdata[8:0];
        yttm_pkg::REG_HEIGHT_MBS:   height_mbs_q   <= pwdata[8:0];
        yttm_pkg::REG_FIRST_MB_ROW: first_mb_row_q <= pwdata[7:0];
        yttm_pkg::REG_MB_ROW_COUNT: mb_row_count_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      yttm_pkg::REG_WIDTH_MBS:    prdata = {23'd0, width_mbs_q};
      yttm_pkg::REG_HEIGHT_MBS:   prdata = {23'd0, height_mbs_q};
      yttm_pkg::REG_FIRST_MB_ROW: prdata = {24'd0, first_mb_row_q};
      yttm_pkg::REG_MB_ROW_COUNT: prdata = {23'd0, mb_row_count_q};
      default:                    prdata = '0;
    endcase
  end

  assign cfg_o.width_mbs    = clamp(width_mbs_q, MaxCols);
  assign cfg_o.height_mbs   = clamp(height_mbs_q, MaxRows);
  assign cfg_o.first_mb_row = first_mb_row_q;
  assign cfg_o.row_count    = clamp(mb_row_count_q, MaxRows);
  assign cfg_o.clr          = wr_en;

endmodule

// File: rtl/yuyv_to_tiled_420_mb.sv
// channel   dir  modport            payload
// pix_in    in   yttm_pix_if.sink   pixel_pair
// mb_out    out  yttm_mb_if.source  luma/chroma offsets and bytes, band_done
// apb       in   psel/penable/...   width_mbs, height_mbs, first_mb_row, mb_row_count
//
// one transfer per cycle sustained while mb_out is ready; stage one and stage two registers lie from pix_in to mb_out
// stage one captures counters and row split, stage two does the tile multiply and adds
// rst_ni clears counters and pipeline valids, registers take their reset values
// a stall on mb_out holds stage two; pix_in stays ready while stage one can move
// a register write returns both counters to the band start
module yuyv_to_tiled_420_mb #(
  parameter int unsigned MAX_MB_COLS = yttm_pkg::MAX_MB_COLS_DEF,
  parameter int unsigned MAX_MB_ROWS = yttm_pkg::MAX_MB_ROWS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [yttm_pkg::PADDR_W-1:0]  paddr,
  input  logic [yttm_pkg::PDATA_W-1:0]  pwdata,
  output logic [yttm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  yttm_pix_if.sink                      pix_in,
  yttm_mb_if.source                     mb_out
);

  yttm_pkg::cfg_t cfg;

  logic [10:0] pair_col_q, pair_col_d;
  logic [11:0] row_q, row_d;
  logic [11:0] pairs_per_row;
  logic [12:0] rows_in_band;
  logic        last_col, last_row;
  logic [12:0] frame_row;
  logic        in_xfer, s2_adv;

  logic        s1_valid_q;
  logic [31:0] s1_word_q;
  logic [8:0]  s1_mb_row_q;
  logic [3:0]  s1_row_in_mb_q;
  logic [7:0]  s1_mb_col_q;
  logic [2:0]  s1_pair_q;
  logic        s1_done_q;

  logic [17:0] mb_row_base;
  logic [17:0] mb_index;
  logic [17:0] frame_mbs;
  logic [24:0] luma_size;
  logic [24:0] uoff;

  logic        out_valid_q;
  logic [23:0] luma_offset_q;
  logic [15:0] luma_bytes_q;
  logic        chroma_valid_q;
  logic [24:0] u_offset_q, v_offset_q;
  logic [7:0]  u_byte_q, v_byte_q;
  logic        band_done_q;

  yttm_cfg_regs #(
    .MAX_MB_COLS(MAX_MB_COLS),
    .MAX_MB_ROWS(MAX_MB_ROWS)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  assign s2_adv       = !out_valid_q || mb_out.ready;
  assign pix_in.ready = !s1_valid_q || s2_adv;
  assign in_xfer      = pix_in.valid && pix_in.ready;

  assign pairs_per_row = {cfg.width_mbs, 3'd0};
  assign rows_in_band  = {cfg.row_count, 4'd0};
  assign last_col      = ({1'b0, pair_col_q} + 12'd1) >= pairs_per_row;
  assign last_row      = ({1'b0, row_q} + 13'd1) >= rows_in_band;
  assign frame_row     = {1'b0, cfg.first_mb_row, 4'd0} + {1'b0, row_q};

  always_comb begin
    pair_col_d = pair_col_q;
    row_d      = row_q;
    if (cfg.clr) begin
      pair_col_d = '0;
      row_d      = '0;
    end else if (in_xfer) begin
      if (last_col) begin
        pair_col_d = '0;
        row_d      = last_row ? '0 : row_q + 12'd1;
      end else begin
        pair_col_d = pair_col_q + 11'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_col_q <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      pair_col_q <= pair_col_d;
      row_q      <= row_d;
      if (pix_in.ready) begin
        s1_valid_q <= pix_in.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_word_q      <= pix_in.pixel_pair;
      s1_mb_row_q    <= frame_row[12:4];
      s1_row_in_mb_q <= frame_row[3:0];
      s1_mb_col_q    <= pair_col_q[10:3];
      s1_pair_q      <= pair_col_q[2:0];
      s1_done_q      <= last_col && last_row;
    end
  end

  assign mb_row_base = s1_mb_row_q * cfg.width_mbs;
  assign mb_index    = mb_row_base + {10'd0, s1_mb_col_q};
  assign frame_mbs   = cfg.width_mbs * cfg.height_mbs;
  assign luma_size   = {frame_mbs[16:0], 8'd0};
  assign uoff        = luma_size + {mb_index, s1_row_in_mb_q[3:1], 1'b0, s1_pair_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && s1_valid_q) begin
      luma_offset_q <= {mb_index[15:0], s1_row_in_mb_q, s1_pair_q, 1'b0};
      luma_bytes_q  <= {s1_word_q[23:16], s1_word_q[7:0]};
      band_done_q   <= s1_done_q;
      if (!s1_row_in_mb_q[0]) begin
        chroma_valid_q <= 1'b1;
        u_offset_q     <= uoff;
        // bit 3 of the chroma offset is always clear
        v_offset_q     <= uoff | 25'd8;
        u_byte_q       <= s1_word_q[15:8];
        v_byte_q       <= s1_word_q[31:24];
      end else begin
        chroma_valid_q <= 1'b0;
        u_offset_q     <= '0;
        v_offset_q     <= '0;
        u_byte_q       <= '0;
        v_byte_q       <= '0;
      end
    end
  end

  assign mb_out.valid        = out_valid_q;
  assign mb_out.luma_offset  = luma_offset_q;
  assign mb_out.luma_bytes   = luma_bytes_q;
  assign mb_out.chroma_valid = chroma_valid_q;
  assign mb_out.u_offset     = u_offset_q;
  assign mb_out.u_byte       = u_byte_q;
  assign mb_out.v_offset     = v_offset_q;
  assign mb_out.v_byte       = v_byte_q;
  assign mb_out.band_done    = band_done_q;

  a_clr_counters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg.clr |=> (pair_col_q == '0) && (row_q == '0))
    else $error("counters not cleared by register write");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pair_col_q} < pairs_per_row)
    else $error("pair column beyond row");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, row_q} < rows_in_band)
    else $error("row beyond band");

  a_odd_row_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !chroma_valid_q) |-> (u_offset_q == '0) && (v_offset_q == '0))
    else $error("chroma offsets on odd row");

  a_v_after_u: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && chroma_valid_q) |-> (v_offset_q == u_offset_q + 25'd8))
    else $error("v offset not u offset plus eight");

endmodule

// File: tb/yuyv_to_tiled_420_mb_tb.sv
`timescale 1ns / 1ps

module yuyv_to_tiled_420_mb_tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_LEN = 150;

  typedef struct packed {
    logic [23:0] luma_offset;
    logic [15:0] luma_bytes;
    logic        chroma_valid;
    logic [24:0] u_offset;
    logic [7:0]  u_byte;
    logic [24:0] v_offset;
    logic [7:0]  v_byte;
    logic        band_done;
  } tile_word_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [yttm_pkg::PADDR_W-1:0]   paddr;
  logic [yttm_pkg::PDATA_W-1:0]   pwdata;
  logic [yttm_pkg::PDATA_W-1:0]   prdata;
  logic                           pready;

  yttm_pix_if pix ();
  yttm_mb_if  mb ();

  yuyv_to_tiled_420_mb dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pix_in  (pix),
    .mb_out  (mb)
  );

  // predictor state
  logic [yttm_pkg::MB_DIM_W-1:0]    cfg_width;
  logic [yttm_pkg::MB_DIM_W-1:0]    cfg_height;
  logic [yttm_pkg::FIRST_ROW_W-1:0] cfg_first_row;
  logic [yttm_pkg::MB_DIM_W-1:0]    cfg_row_count;
  logic [10:0]                      col_pos;
  logic [11:0]                      band_row;

  tile_word_t  expected_tiles[$];
  tile_word_t  want_tile;
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;

  // sender bursts and receiver stall pattern
  int unsigned burst_left = 0;
  int unsigned gap_max = 0;
  logic [15:0] stall_mask = 16'hFFFF;
  logic [3:0]  stall_phase = '0;
  logic        hold_toggle = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_cnt = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_cnt <= HOLD_LEN;
      mb.ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      mb.ready <= 1'b0;
    end else begin
      mb.ready <= stall_mask[stall_phase];
      stall_phase <= stall_phase + 1'b1;
    end
  end

  task automatic report_mismatch(input string field, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch %s: got 0x%0h want 0x%0h (cycle %0d)", field, got, want, cycle_count);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && mb.valid && mb.ready) begin
      if (expected_tiles.size() == 0) begin
        report_mismatch("unexpected transfer", mb.luma_offset, 0);
      end else begin
        want_tile = expected_tiles.pop_front();
        if (mb.luma_offset !== want_tile.luma_offset)
          report_mismatch("luma_offset", mb.luma_offset, want_tile.luma_offset);
        if (mb.luma_bytes !== want_tile.luma_bytes)
          report_mismatch("luma_bytes", mb.luma_bytes, want_tile.luma_bytes);
        if (mb.chroma_valid !== want_tile.chroma_valid)
          report_mismatch("chroma_valid", mb.chroma_valid, want_tile.chroma_valid);
        if (mb.u_offset !== want_tile.u_offset)
          report_mismatch("u_offset", mb.u_offset, want_tile.u_offset);
        if (mb.u_byte !== want_tile.u_byte)
          report_mismatch("u_byte", mb.u_byte, want_tile.u_byte);
        if (mb.v_offset !== want_tile.v_offset)
          report_mismatch("v_offset", mb.v_offset, want_tile.v_offset);
        if (mb.v_byte !== want_tile.v_byte)
          report_mismatch("v_byte", mb.v_byte, want_tile.v_byte);
        if (mb.band_done !== want_tile.band_done)
          report_mismatch("band_done", mb.band_done, want_tile.band_done);
      end
    end
  end

  function automatic int unsigned clamp_dim(input logic [8:0] value, input int unsigned hi);
    if (value == 0) return 1;
    if (value > hi) return hi;
    return int'(value);
  endfunction

  function automatic tile_word_t predict_tile(input logic [31:0] word);
    int unsigned w, h, rows, pairs_per_row, col, brow, frame_row, row_in_mb, pair_in_mb;
    longint unsigned mb_index, uoff;
    bit last_col, last_row;
    tile_word_t res;
    w = clamp_dim(cfg_width, yttm_pkg::MAX_MB_COLS_DEF);
    h = clamp_dim(cfg_height, yttm_pkg::MAX_MB_ROWS_DEF);
    rows = clamp_dim(cfg_row_count, yttm_pkg::MAX_MB_ROWS_DEF) * 16;
    pairs_per_row = w * 8;
    col = col_pos;
    brow = band_row;
    frame_row = int'(cfg_first_row) * 16 + brow;
    row_in_mb = frame_row % 16;
    pair_in_mb = col % 8;
    mb_index = longint'(frame_row / 16) * w + col / 8;
    last_col = (col + 1) >= pairs_per_row;
    last_row = (brow + 1) >= rows;
    res = '0;
    res.luma_offset = 24'((mb_index << 8) + row_in_mb * 16 + pair_in_mb * 2);
    res.luma_bytes = {word[23:16], word[7:0]};
    if (row_in_mb % 2 == 0) begin
      uoff = longint'(w) * h * 256 + (mb_index << 7) + (row_in_mb / 2) * 16 + pair_in_mb;
      res.chroma_valid = 1'b1;
      res.u_offset = 25'(uoff);
      res.u_byte = word[15:8];
      res.v_offset = 25'(uoff + 8);
      res.v_byte = word[31:24];
    end
    res.band_done = last_col && last_row;
    if (last_col) begin
      col_pos = '0;
      band_row = last_row ? 12'd0 : 12'(brow + 1);
    end else begin
      col_pos = 11'(col + 1);
    end
    return res;
  endfunction

  task automatic write_reg(input yttm_pkg::reg_idx_e idx, input logic [8:0] value);
    logic [31:0] data;
    data = $urandom;
    data[8:0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      yttm_pkg::REG_WIDTH_MBS:    cfg_width = data[8:0];
      yttm_pkg::REG_HEIGHT_MBS:   cfg_height = data[8:0];
      yttm_pkg::REG_FIRST_MB_ROW: cfg_first_row = data[7:0];
      yttm_pkg::REG_MB_ROW_COUNT: cfg_row_count = data[8:0];
      default: ;
    endcase
    col_pos = '0;
    band_row = '0;
  endtask

  task automatic set_frame(input logic [8:0] width, input logic [8:0] height,
                           input logic [8:0] first_row, input logic [8:0] row_count);
    write_reg(yttm_pkg::REG_WIDTH_MBS, width);
    write_reg(yttm_pkg::REG_HEIGHT_MBS, height);
    write_reg(yttm_pkg::REG_FIRST_MB_ROW, first_row);
    write_reg(yttm_pkg::REG_MB_ROW_COUNT, row_count);
  endtask

  task automatic send_pair(input logic [31:0] word);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        pix.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    pix.valid <= 1'b1;
    pix.pixel_pair <= word;
    do @(posedge clk_i); while (!pix.ready);
    items_sent++;
    expected_tiles.push_back(predict_tile(word));
  endtask

  task automatic drain_tiles();
    pix.valid <= 1'b0;
    while (expected_tiles.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic shuffle_flow();
    stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    burst_left = 0;
  endtask

  task automatic test_directed();
    // reset settings, extreme words
    send_pair(32'h0000_0000);
    send_pair(32'hFFFF_FFFF);
    send_pair(32'h00FF_00FF);
    send_pair(32'hFF00_FF00);
    drain_tiles();
    // zero registers clamp to one, run past the first row into an odd row
    set_frame(9'd0, 9'd0, 9'd0, 9'd0);
    repeat (10) send_pair($urandom);
    drain_tiles();
    // registers above range clamp to the maximum
    set_frame(9'd511, 9'd511, 9'd255, 9'd511);
    repeat (4) send_pair($urandom);
    drain_tiles();
    // write mid-row returns counters to band start
    write_reg(yttm_pkg::REG_FIRST_MB_ROW, 9'd3);
    repeat (3) send_pair($urandom);
    drain_tiles();
  endtask

  task automatic test_random_bands();
    int unsigned w_reg, r_reg, band_len, count;
    while (items_sent < 1350) begin
      drain_tiles();
      w_reg = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 2);
      r_reg = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 2);
      if (w_reg == 2 && r_reg == 2) r_reg = 1;
      set_frame(9'(w_reg), 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                9'(r_reg));
      band_len = clamp_dim(cfg_width, yttm_pkg::MAX_MB_COLS_DEF) * 8
                 * clamp_dim(cfg_row_count, yttm_pkg::MAX_MB_ROWS_DEF) * 16;
      // broken bands get cut short by the next register write
      count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, band_len - 1)
                                          : band_len + $urandom_range(0, 24);
      shuffle_flow();
      repeat (count) send_pair($urandom);
    end
    drain_tiles();
  endtask

  task automatic test_wide_frame();
    set_frame(9'd256, 9'd256, 9'd255, 9'd256);
    shuffle_flow();
    repeat (300) send_pair($urandom);
    drain_tiles();
    set_frame(9'd300, 9'd0, 9'd0, 9'd1);
    shuffle_flow();
    repeat (100) send_pair($urandom);
    drain_tiles();
  endtask

  task automatic test_backpressure();
    set_frame(9'd1, 9'd8, 9'd3, 9'd1);
    stall_mask = 16'hFFFF;
    gap_max = 0;
    burst_left = 0;
    hold_toggle = ~hold_toggle;
    repeat (60) send_pair($urandom);
    drain_tiles();
    repeat (20) send_pair($urandom);
    drain_tiles();
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pix.valid = 1'b0;
    pix.pixel_pair = '0;
    cfg_width = yttm_pkg::WIDTH_MBS_RST;
    cfg_height = yttm_pkg::HEIGHT_MBS_RST;
    cfg_first_row = yttm_pkg::FIRST_MB_ROW_RST;
    cfg_row_count = yttm_pkg::MB_ROW_COUNT_RST;
    col_pos = '0;
    band_row = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_bands();
    test_wide_frame();
    test_backpressure();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
